// ===== src/hkr_pkg.sv =====
// types, constants and usage-to-key-code mapping for the boot keyboard report decoder
// no dependencies; used by every module of the block
package hkr_pkg;

  localparam int unsigned REPORT_SLOTS = 6;
  localparam logic [7:0] MIN_REPORT_LEN = 8'd8;
  localparam logic [7:0] SHIFT_MASK = 8'h22;
  localparam logic [7:0] USAGE_NONE = 8'h00;
  localparam logic [7:0] USAGE_ROLLOVER = 8'h01;

  // usage codes with fixed meaning
  localparam logic [7:0] USAGE_A = 8'h04;
  localparam logic [7:0] USAGE_Z = 8'h1d;
  localparam logic [7:0] USAGE_1 = 8'h1e;
  localparam logic [7:0] USAGE_0 = 8'h27;
  localparam logic [7:0] USAGE_ENTER = 8'h28;
  localparam logic [7:0] USAGE_ESCAPE = 8'h29;
  localparam logic [7:0] USAGE_BSPACE = 8'h2a;
  localparam logic [7:0] USAGE_TAB = 8'h2b;
  localparam logic [7:0] USAGE_SPACE = 8'h2c;
  localparam logic [7:0] USAGE_MINUS = 8'h2d;
  localparam logic [7:0] USAGE_EQUAL = 8'h2e;
  localparam logic [7:0] USAGE_LBRACKET = 8'h2f;
  localparam logic [7:0] USAGE_RBRACKET = 8'h30;
  localparam logic [7:0] USAGE_BSLASH = 8'h31;
  localparam logic [7:0] USAGE_SEMICOLON = 8'h33;
  localparam logic [7:0] USAGE_QUOTE = 8'h34;
  localparam logic [7:0] USAGE_GRAVE = 8'h35;
  localparam logic [7:0] USAGE_COMMA = 8'h36;
  localparam logic [7:0] USAGE_PERIOD = 8'h37;
  localparam logic [7:0] USAGE_SLASH = 8'h38;
  localparam logic [7:0] USAGE_RIGHT = 8'h4f;
  localparam logic [7:0] USAGE_LEFT = 8'h50;
  localparam logic [7:0] USAGE_DOWN = 8'h51;
  localparam logic [7:0] USAGE_UP = 8'h52;

  // key codes outside ascii
  localparam logic [7:0] KEY_SELECT = 8'd128;
  localparam logic [7:0] KEY_BACK = 8'd129;
  localparam logic [7:0] KEY_RIGHT = 8'd130;
  localparam logic [7:0] KEY_LEFT = 8'd131;
  localparam logic [7:0] KEY_DOWN = 8'd132;
  localparam logic [7:0] KEY_UP = 8'd133;
  localparam logic [7:0] KEY_NONE = 8'd0;

  localparam logic [7:0] DIGIT_PLAIN [10] = '{
    8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30
  };
  localparam logic [7:0] DIGIT_SHIFT [10] = '{
    8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5e, 8'h26, 8'h2a, 8'h28, 8'h29
  };

  typedef struct packed {
    logic [7:0] modifiers;
    logic [7:0] key_slot0;
    logic [7:0] key_slot1;
    logic [7:0] key_slot2;
    logic [7:0] key_slot3;
    logic [7:0] key_slot4;
    logic [7:0] key_slot5;
    logic [7:0] report_length;
  } hkr_in_t;

  typedef struct packed {
    logic       is_press;
    logic [7:0] key_code;
    logic       last;
  } hkr_out_t;

  // what one lane found for its slot
  typedef struct packed {
    logic       release_ev;
    logic       press_ev;
    logic [7:0] next_code;
  } hkr_lane_res_t;

  function automatic logic [7:0] map_usage(input logic [7:0] u, input logic sh);
    logic [7:0] off_letter;
    logic [7:0] off_digit;
    logic [7:0] code;
    off_letter = u - USAGE_A;
    off_digit = u - USAGE_1;
    code = KEY_NONE;
    case (u) inside
      [USAGE_A:USAGE_Z]: code = (sh ? 8'h41 : 8'h61) + off_letter;
      [USAGE_1:USAGE_0]: code = sh ? DIGIT_SHIFT[off_digit[3:0]] : DIGIT_PLAIN[off_digit[3:0]];
      USAGE_ENTER:       code = KEY_SELECT;
      USAGE_ESCAPE:      code = KEY_BACK;
      USAGE_BSPACE:      code = 8'h08;
      USAGE_TAB:         code = 8'h09;
      USAGE_SPACE:       code = 8'h20;
      USAGE_MINUS:       code = sh ? 8'h5f : 8'h2d;
      USAGE_EQUAL:       code = sh ? 8'h2b : 8'h3d;
      USAGE_LBRACKET:    code = sh ? 8'h7b : 8'h5b;
      USAGE_RBRACKET:    code = sh ? 8'h7d : 8'h5d;
      USAGE_BSLASH:      code = sh ? 8'h7c : 8'h5c;
      USAGE_SEMICOLON:   code = sh ? 8'h3a : 8'h3b;
      USAGE_QUOTE:       code = sh ? 8'h22 : 8'h27;
      USAGE_GRAVE:       code = sh ? 8'h7e : 8'h60;
      USAGE_COMMA:       code = sh ? 8'h3c : 8'h2c;
      USAGE_PERIOD:      code = sh ? 8'h3e : 8'h2e;
      USAGE_SLASH:       code = sh ? 8'h3f : 8'h2f;
      USAGE_RIGHT:       code = KEY_RIGHT;
      USAGE_LEFT:        code = KEY_LEFT;
      USAGE_DOWN:        code = KEY_DOWN;
      USAGE_UP:          code = KEY_UP;
      default:           code = KEY_NONE;
    endcase
    return code;
  endfunction

endpackage

// ===== src/hkr_lane.sv =====
// one slot lane: release check for the held usage, retain lookup and mapping for the new one
// depends on hkr_pkg
module hkr_lane #(
  parameter int unsigned KEY_SLOTS = 6,
  parameter int unsigned LANE = 0
) (
  input  logic [7:0]            held_usage_i [KEY_SLOTS],
  input  logic [7:0]            held_code_i  [KEY_SLOTS],
  input  logic [7:0]            cur_i        [KEY_SLOTS],
  input  logic                  shift_i,
  output hkr_pkg::hkr_lane_res_t res_o
);
  import hkr_pkg::*;

  logic       gone;
  logic       kept;
  logic [7:0] kept_code;
  logic [7:0] mapped;

  // old usage of this slot missing from the new report
  always_comb begin
    gone = 1'b1;
    for (int j = 0; j < KEY_SLOTS; j++) begin
      if (cur_i[j] == held_usage_i[LANE]) gone = 1'b0;
    end
  end

  // first old slot holding the new usage wins, so scan from the top down
  always_comb begin
    kept = 1'b0;
    kept_code = KEY_NONE;
    for (int j = KEY_SLOTS - 1; j >= 0; j--) begin
      if (held_usage_i[j] == cur_i[LANE]) begin
        kept = 1'b1;
        kept_code = held_code_i[j];
      end
    end
  end

  assign mapped = map_usage(cur_i[LANE], shift_i);

  always_comb begin
    res_o.release_ev = (held_usage_i[LANE] != USAGE_NONE) && gone
                       && (held_code_i[LANE] != KEY_NONE);
    res_o.press_ev = 1'b0;
    res_o.next_code = KEY_NONE;
    if (cur_i[LANE] != USAGE_NONE) begin
      if (kept) begin
        res_o.next_code = kept_code;
      end else begin
        res_o.next_code = mapped;
        res_o.press_ev = (mapped != KEY_NONE);
      end
    end
  end

endmodule

// ===== src/hkr_emitter.sv =====
// merge stage: holds one report's event set and sends it out one event per transfer
// depends on hkr_pkg
module hkr_emitter #(
  parameter int unsigned KEY_SLOTS = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  logic [2*KEY_SLOTS-1:0] ev_mask_i,
  input  logic [7:0]           ev_code_i [2*KEY_SLOTS],
  output logic                 take_ok_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output hkr_pkg::hkr_out_t    out_data_o
);
  import hkr_pkg::*;

  localparam int unsigned NUM_EVENTS = 2 * KEY_SLOTS;

  // releases sit in the low half, presses in the high half
  logic [NUM_EVENTS-1:0] mask_q, mask_d;
  logic [7:0]            code_q [NUM_EVENTS];
  logic [NUM_EVENTS-1:0] pick;
  logic [NUM_EVENTS-1:0] rest;
  logic [7:0]            pick_code;
  logic                  pop;
  logic                  out_valid_q, out_valid_d;
  hkr_out_t              out_q, out_d;

  assign pick = mask_q & (~mask_q + NUM_EVENTS'(1));
  assign rest = mask_q & ~pick;

  always_comb begin
    pick_code = '0;
    for (int e = 0; e < NUM_EVENTS; e++) begin
      pick_code = pick_code | (code_q[e] & {8{pick[e]}});
    end
  end

  assign pop = (mask_q != '0) && (!out_valid_q || !out_stall_i);
  assign take_ok_o = (mask_q == '0) || (pop && (rest == '0));

  always_comb begin
    mask_d = mask_q;
    if (pop) mask_d = rest;
    if (load_i) mask_d = ev_mask_i;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d = out_q;
    if (pop) begin
      out_valid_d = 1'b1;
      out_d.is_press = |pick[NUM_EVENTS-1:KEY_SLOTS];
      out_d.key_code = pick_code;
      out_d.last = (rest == '0);
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (load_i) code_q <= ev_code_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (mask_q == '0) || (pop && (rest == '0)))
    else $error("event set loaded over pending events");
  a_pick_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> $onehot(pick))
    else $error("event pick not one-hot");
  a_rest_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && (rest != '0)) |=> (mask_q != '0))
    else $error("pending events lost");
  a_last_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && (rest == '0) && !load_i) |=> (mask_q == '0))
    else $error("events left after last");
`endif

endmodule

// ===== src/hid_keyboard_report_to_key_events.sv =====
// top level of the boot keyboard report decoder: held-key state, slot lanes and event merge
// depends on hkr_pkg, hkr_lane and hkr_emitter
//
//  channel | valid      | stall      | payload
//  --------+------------+------------+---------------------------
//  report  | in_valid_i | in_stall_o | in_data_i  (hkr_in_t)
//  event   | out_valid_o| out_stall_i| out_data_o (hkr_out_t)
//
// a report is decoded in the cycle of its transfer: the lanes compare it against the held
// state, which is updated at that edge unless the report is too short or flags rollover;
// events then leave one per cycle from the merge stage while the output is not stalled.
// the next report is taken in the cycle the last event of the previous one moves to the
// output register. reset clears the held usages and codes. a stalled output holds its event;
// the input stalls only while events of the previous report are still queued.
module hid_keyboard_report_to_key_events #(
  parameter int unsigned KEY_SLOTS = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  hkr_pkg::hkr_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output hkr_pkg::hkr_out_t out_data_o
);
  import hkr_pkg::*;

  localparam int unsigned NUM_EVENTS = 2 * KEY_SLOTS;

  logic [7:0]            held_usage_q [KEY_SLOTS];
  logic [7:0]            held_code_q  [KEY_SLOTS];
  logic [7:0]            rep_slot     [REPORT_SLOTS];
  logic [7:0]            cur          [KEY_SLOTS];
  hkr_lane_res_t         lane_res     [KEY_SLOTS];
  logic [NUM_EVENTS-1:0] ev_mask;
  logic [7:0]            ev_code      [NUM_EVENTS];
  logic                  shift;
  logic                  rollover;
  logic                  report_ok;
  logic                  take_ok;
  logic                  accept;
  logic                  load;

  assign rep_slot[0] = in_data_i.key_slot0;
  assign rep_slot[1] = in_data_i.key_slot1;
  assign rep_slot[2] = in_data_i.key_slot2;
  assign rep_slot[3] = in_data_i.key_slot3;
  assign rep_slot[4] = in_data_i.key_slot4;
  assign rep_slot[5] = in_data_i.key_slot5;

  for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_lane
    if (i < REPORT_SLOTS) begin : g_used
      assign cur[i] = rep_slot[i];
    end else begin : g_extra
      assign cur[i] = USAGE_NONE;
    end

    hkr_lane #(
      .KEY_SLOTS(KEY_SLOTS),
      .LANE     (i)
    ) u_lane (
      .held_usage_i(held_usage_q),
      .held_code_i (held_code_q),
      .cur_i       (cur),
      .shift_i     (shift),
      .res_o       (lane_res[i])
    );

    assign ev_mask[i] = lane_res[i].release_ev;
    assign ev_mask[KEY_SLOTS+i] = lane_res[i].press_ev;
    assign ev_code[i] = held_code_q[i];
    assign ev_code[KEY_SLOTS+i] = lane_res[i].next_code;
  end

  assign shift = (in_data_i.modifiers & SHIFT_MASK) != 8'h00;

  always_comb begin
    rollover = 1'b0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (cur[i] == USAGE_ROLLOVER) rollover = 1'b1;
    end
  end

  assign report_ok = (in_data_i.report_length >= MIN_REPORT_LEN) && !rollover;
  assign accept = in_valid_i && take_ok;
  assign load = accept && report_ok;
  assign in_stall_o = !take_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
        held_usage_q[i] <= USAGE_NONE;
        held_code_q[i] <= KEY_NONE;
      end
    end else if (load) begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
        held_usage_q[i] <= cur[i];
        held_code_q[i] <= lane_res[i].next_code;
      end
    end
  end

  hkr_emitter #(
    .KEY_SLOTS(KEY_SLOTS)
  ) u_emitter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .ev_mask_i  (ev_mask),
    .ev_code_i  (ev_code),
    .take_ok_o  (take_ok),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule
